// File: design/amg_pkg.sv
// ----------------------------------------------------------------------------
// amg_pkg - shared types and constants of the adjacency matrix graph store
// Operation and status codes, controller states, request and response
// layouts and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package amg_pkg;

   // Default sizes, handed to the top level as parameter defaults
   localparam int unsigned DEF_MAX_VERTICES = 16;
   localparam int unsigned DEF_KEY_BITS     = 32;

   // Fixed field widths
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned KEY_IN_W  = 32;
   localparam int unsigned WEIGHT_W  = 32;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned SLOT_OUT_W  = 4;
   localparam int unsigned TOTAL_OUT_W = 5;

   // One edge entry: presence bit above the cost
   localparam int unsigned EDGE_W = WEIGHT_W + 1;

   // Stream payload widths
   localparam int unsigned REQ_TDATA_W = 96;
   localparam int unsigned REQ_TUSER_W = KIND_W;
   localparam int unsigned RSP_TDATA_W = 48;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD_VERTEX = 3'd0,
      KIND_DEL_VERTEX = 3'd1,
      KIND_ADD_EDGE   = 3'd2,
      KIND_DEL_EDGE   = 3'd3,
      KIND_FIND       = 3'd4,
      KIND_QUERY_EDGE = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_DUPLICATE   = 3'd1,
      STAT_FULL        = 3'd2,
      STAT_NOT_FOUND   = 3'd3,
      STAT_EDGE_EXISTS = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SCAN_END,
      ST_DECIDE,
      ST_EDGE,
      ST_MIRROR,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      kind_type                   kind;
      logic [KEY_IN_W-1:0]        key_a;
      logic [KEY_IN_W-1:0]        key_b;
      logic signed [WEIGHT_W-1:0] edge_weight;
   } req_type;

   // First member in the highest bits: status ends up lowest
   typedef struct packed {
      logic                       is_full;
      logic                       is_empty;
      logic [TOTAL_OUT_W-1:0]     vertex_total;
      logic signed [WEIGHT_W-1:0] edge_value;
      logic                       edge_found;
      logic [SLOT_OUT_W-1:0]      slot;
      status_type                 status;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/adjacency_matrix_graph_store_top.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_top - graph store over a vertex key table and
// an edge matrix held in synchronous RAM
//
//  channel  dir  handshake                payload
//  req_     in   req_tvalid / req_tready  tdata key_a, key_b, edge_weight;
//                                         tuser kind
//  rsp_     out  rsp_tvalid / rsp_tready  tdata status, slot, edge_found,
//                                         edge_value, vertex_total, is_empty,
//                                         is_full
//  csr_     in   csr_valid / csr_ready    data directed
//
// Each operation scans the key table at one key RAM read per cycle. Edge
// operations with both ends found then read the edge RAM; a new add edge
// or a delete edge writes the entry and, in undirected mode, its mirror. A
// successful add vertex wipes the new slot's row and column at one edge
// RAM write per cycle. A new request is taken the cycle after the previous
// result enters the output register, even while that result waits. Reset
// clears the control state, mode bit, response valid, slot valid bits and
// vertex count; neither RAM is cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_matrix_graph_store_top #(
   parameter int unsigned MAX_VERTICES = amg_pkg::DEF_MAX_VERTICES,
   parameter int unsigned KEY_BITS     = amg_pkg::DEF_KEY_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request stream
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // [31:0] key_a, [63:32] key_b, [95:64] edge_weight
   input  wire logic [amg_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [2:0] kind
   input  wire logic [amg_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // response stream
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [2:0] status, [6:3] slot, [7] edge_found, [39:8] edge_value,
   // [44:40] vertex_total, [45] is_empty, [46] is_full, [47] zero
   output      logic [amg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // mode register write
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic                             csr_data
);

   import amg_pkg::*;

   localparam int unsigned SLOT_W  = $clog2(MAX_VERTICES);
   localparam int unsigned EDGE_AW = $clog2(MAX_VERTICES * MAX_VERTICES);

   logic    directed_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   req_type req;
   rsp_type rsp;
   logic    out_free;
   logic    done;

   logic                key_we;
   logic [SLOT_W-1:0]   key_waddr;
   logic [KEY_BITS-1:0] key_wdata;
   logic [SLOT_W-1:0]   key_raddr;
   logic [KEY_BITS-1:0] key_rdata;

   logic                edge_we;
   logic [EDGE_AW-1:0]  edge_waddr;
   logic [EDGE_W-1:0]   edge_wdata;
   logic [EDGE_AW-1:0]  edge_raddr;
   logic [EDGE_W-1:0]   edge_rdata;

   // Unpack the request
   always_comb begin
      req.kind        = kind_type'(req_tuser);
      req.key_a       = req_tdata[KEY_IN_W-1:0];
      req.key_b       = req_tdata[2*KEY_IN_W-1:KEY_IN_W];
      req.edge_weight = req_tdata[2*KEY_IN_W+WEIGHT_W-1:2*KEY_IN_W];
   end

   // Mode register, written on any transfer
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         directed_ff <= 1'b0;
      end else if (csr_valid) begin
         directed_ff <= csr_data;
      end
   end

   // Output register: load on done, drop on transfer
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   amg_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .KEY_BITS     (KEY_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .directed   (directed_ff),
      .out_free   (out_free),
      .done       (done),
      .rsp        (rsp),
      .key_we     (key_we),
      .key_waddr  (key_waddr),
      .key_wdata  (key_wdata),
      .key_raddr  (key_raddr),
      .key_rdata  (key_rdata),
      .edge_we    (edge_we),
      .edge_waddr (edge_waddr),
      .edge_wdata (edge_wdata),
      .edge_raddr (edge_raddr),
      .edge_rdata (edge_rdata)
   );

   // Vertex keys, one word per slot
   amg_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

   // Edge matrix, presence bit and cost per entry
   amg_ram #(
      .WIDTH (EDGE_W),
      .DEPTH (MAX_VERTICES * MAX_VERTICES)
   ) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

endmodule

`default_nettype wire

// File: design/amg_ram.sv
// ----------------------------------------------------------------------------
// amg_ram - generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module amg_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/amg_ctrl.sv
// ----------------------------------------------------------------------------
// amg_ctrl - operation sequencer of the graph store
// Scans the key memory once per operation and decides the outcome. Edge
// operations then read and may write the edge memory; an added vertex's
// row and column are wiped. Slot valid bits and vertex count are flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module amg_ctrl #(
   parameter int unsigned MAX_VERTICES = amg_pkg::DEF_MAX_VERTICES,
   parameter int unsigned KEY_BITS     = amg_pkg::DEF_KEY_BITS
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   // request side
   input  wire logic                                         req_valid,
   output      logic                                         req_ready,
   input  wire amg_pkg::req_type                             req,
   // mode and result register handshake
   input  wire logic                                         directed,
   input  wire logic                                         out_free,
   output      logic                                         done,
   output      amg_pkg::rsp_type                             rsp,
   // key memory
   output      logic                                         key_we,
   output      logic [$clog2(MAX_VERTICES)-1:0]              key_waddr,
   output      logic [KEY_BITS-1:0]                          key_wdata,
   output      logic [$clog2(MAX_VERTICES)-1:0]              key_raddr,
   input  wire logic [KEY_BITS-1:0]                          key_rdata,
   // edge memory
   output      logic                                         edge_we,
   output      logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0] edge_waddr,
   output      logic [amg_pkg::EDGE_W-1:0]                   edge_wdata,
   output      logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0] edge_raddr,
   input  wire logic [amg_pkg::EDGE_W-1:0]                   edge_rdata
);

   import amg_pkg::*;

   localparam int unsigned SLOT_W  = $clog2(MAX_VERTICES);
   localparam int unsigned CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int unsigned EDGE_AW = $clog2(MAX_VERTICES * MAX_VERTICES);
   localparam int unsigned CLR_W   = $clog2(2 * MAX_VERTICES);

   // Keys compare in their low KEY_BITS bits
   function automatic logic [KEY_BITS-1:0] mask_key(input logic [KEY_IN_W-1:0] k);
      logic [63:0] wide;
      wide = 64'(k);
      return wide[KEY_BITS-1:0];
   endfunction

   // Flat edge index of (row, col)
   function automatic logic [EDGE_AW-1:0] edge_index(input logic [SLOT_W-1:0] row,
                                                     input logic [SLOT_W-1:0] col);
      return EDGE_AW'(EDGE_AW'(row) * EDGE_AW'(MAX_VERTICES) + EDGE_AW'(col));
   endfunction

   state_type                  state_ff, state_in;
   req_type                    op_ff, op_in;
   logic [SLOT_W-1:0]          cnt_ff, cnt_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                       a_hit_ff, a_hit_in;
   logic [SLOT_W-1:0]          a_idx_ff, a_idx_in;
   logic                       b_hit_ff, b_hit_in;
   logic [SLOT_W-1:0]          b_idx_ff, b_idx_in;
   logic                       free_hit_ff, free_hit_in;
   logic [SLOT_W-1:0]          free_idx_ff, free_idx_in;
   logic [MAX_VERTICES-1:0]    slot_used_ff, slot_used_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CLR_W-1:0]           clr_cnt_ff, clr_cnt_in;
   status_type                 res_status_ff, res_status_in;
   logic [SLOT_W-1:0]          res_slot_ff, res_slot_in;
   logic                       res_found_ff, res_found_in;
   logic signed [WEIGHT_W-1:0] res_value_ff, res_value_in;

   logic [KEY_BITS-1:0] ka_key;
   logic [KEY_BITS-1:0] kb_key;
   logic                rd_used;
   logic [CLR_W-1:0]    clr_j;
   logic [7:0]          slot_wide;
   logic [7:0]          total_wide;

   assign ka_key  = mask_key(op_ff.key_a);
   assign kb_key  = mask_key(op_ff.key_b);
   assign rd_used = slot_used_ff[rd_idx_ff];
   assign clr_j   = (clr_cnt_ff < CLR_W'(MAX_VERTICES)) ?
                    clr_cnt_ff : CLR_W'(clr_cnt_ff - CLR_W'(MAX_VERTICES));

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         slot_used_ff <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         slot_used_ff <= slot_used_in;
         count_ff     <= count_in;
      end
   end

   // Operation and scan payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      a_hit_ff      <= a_hit_in;
      a_idx_ff      <= a_idx_in;
      b_hit_ff      <= b_hit_in;
      b_idx_ff      <= b_idx_in;
      free_hit_ff   <= free_hit_in;
      free_idx_ff   <= free_idx_in;
      clr_cnt_ff    <= clr_cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_found_ff  <= res_found_in;
      res_value_ff  <= res_value_in;
   end

   // Next state and memory accesses
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      a_hit_in      = a_hit_ff;
      a_idx_in      = a_idx_ff;
      b_hit_in      = b_hit_ff;
      b_idx_in      = b_idx_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      slot_used_in  = slot_used_ff;
      count_in      = count_ff;
      clr_cnt_in    = clr_cnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_found_in  = res_found_ff;
      res_value_in  = res_value_ff;

      req_ready  = 1'b0;
      done       = 1'b0;
      key_we     = 1'b0;
      key_waddr  = free_idx_ff;
      key_wdata  = ka_key;
      key_raddr  = cnt_ff;
      edge_we    = 1'b0;
      edge_waddr = edge_index(a_idx_ff, b_idx_ff);
      edge_wdata = '0;
      edge_raddr = edge_index(a_idx_ff, b_idx_ff);

      // Compare the key word that arrived this cycle
      if (rd_vld_ff) begin
         if (rd_used && key_rdata == ka_key && !a_hit_ff) begin
            a_hit_in = 1'b1;
            a_idx_in = rd_idx_ff;
         end
         if (rd_used && key_rdata == kb_key && !b_hit_ff) begin
            b_hit_in = 1'b1;
            b_idx_in = rd_idx_ff;
         end
         if (!rd_used && !free_hit_ff) begin
            free_hit_in = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in         = req;
               cnt_in        = '0;
               a_hit_in      = 1'b0;
               b_hit_in      = 1'b0;
               free_hit_in   = 1'b0;
               res_status_in = STAT_OK;
               res_slot_in   = '0;
               res_found_in  = 1'b0;
               res_value_in  = '0;
               state_in      = ST_SEARCH;
            end
         end

         // Issue one key read per cycle
         ST_SEARCH: begin
            rd_vld_in = 1'b1;
            rd_idx_in = cnt_ff;
            if (cnt_ff == SLOT_W'(MAX_VERTICES - 1)) begin
               state_in = ST_SCAN_END;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Last compare lands here
         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            state_in = ST_DONE;
            case (op_ff.kind)
               KIND_ADD_VERTEX: begin
                  if (count_ff >= CNT_W'(MAX_VERTICES)) begin
                     res_status_in = STAT_FULL;
                  end else if (a_hit_ff) begin
                     res_status_in = STAT_DUPLICATE;
                     res_slot_in   = a_idx_ff;
                  end else if (!free_hit_ff) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     // Take the slot, then wipe its row and column
                     key_we                    = 1'b1;
                     slot_used_in[free_idx_ff] = 1'b1;
                     count_in                  = count_ff + 1'b1;
                     res_slot_in               = free_idx_ff;
                     clr_cnt_in                = '0;
                     state_in                  = ST_CLEAR;
                  end
               end
               KIND_DEL_VERTEX: begin
                  if (a_hit_ff) begin
                     slot_used_in[a_idx_ff] = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     res_slot_in = a_idx_ff;
                  end else begin
                     res_status_in = STAT_NOT_FOUND;
                  end
               end
               KIND_FIND: begin
                  if (a_hit_ff) begin
                     res_slot_in = a_idx_ff;
                  end else begin
                     res_status_in = STAT_NOT_FOUND;
                  end
               end
               KIND_ADD_EDGE, KIND_DEL_EDGE, KIND_QUERY_EDGE: begin
                  if (a_hit_ff) begin
                     res_slot_in = a_idx_ff;
                  end
                  if (!a_hit_ff || !b_hit_ff) begin
                     res_status_in = STAT_NOT_FOUND;
                  end else begin
                     // Edge read issued through edge_raddr
                     state_in = ST_EDGE;
                  end
               end
               default: begin
               end
            endcase
         end

         // Edge word for (a, b) is on edge_rdata
         ST_EDGE: begin
            state_in = ST_DONE;
            case (op_ff.kind)
               KIND_ADD_EDGE: begin
                  if (edge_rdata[WEIGHT_W]) begin
                     res_status_in = STAT_EDGE_EXISTS;
                  end else begin
                     edge_we    = 1'b1;
                     edge_wdata = {1'b1, op_ff.edge_weight};
                     if (!directed) begin
                        state_in = ST_MIRROR;
                     end
                  end
               end
               KIND_DEL_EDGE: begin
                  edge_we = 1'b1;
                  if (!directed) begin
                     state_in = ST_MIRROR;
                  end
               end
               KIND_QUERY_EDGE: begin
                  res_found_in = edge_rdata[WEIGHT_W];
                  if (edge_rdata[WEIGHT_W]) begin
                     res_value_in = edge_rdata[WEIGHT_W-1:0];
                  end
               end
               default: begin
               end
            endcase
         end

         // Reverse entry for undirected mode
         ST_MIRROR: begin
            edge_we    = 1'b1;
            edge_waddr = edge_index(b_idx_ff, a_idx_ff);
            if (op_ff.kind == KIND_ADD_EDGE) begin
               edge_wdata = {1'b1, op_ff.edge_weight};
            end
            state_in = ST_DONE;
         end

         // Row of the new slot first, then its column
         ST_CLEAR: begin
            edge_we = 1'b1;
            if (clr_cnt_ff < CLR_W'(MAX_VERTICES)) begin
               edge_waddr = edge_index(res_slot_ff, SLOT_W'(clr_j));
            end else begin
               edge_waddr = edge_index(SLOT_W'(clr_j), res_slot_ff);
            end
            if (clr_cnt_ff == CLR_W'(2 * MAX_VERTICES - 1)) begin
               state_in = ST_DONE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end

         // Hold until the result register can take the transfer
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Pack the result
   assign slot_wide  = 8'(res_slot_ff);
   assign total_wide = 8'(count_ff);

   always_comb begin
      rsp.status       = res_status_ff;
      rsp.slot         = slot_wide[SLOT_OUT_W-1:0];
      rsp.edge_found   = res_found_ff;
      rsp.edge_value   = res_value_ff;
      rsp.vertex_total = total_wide[TOTAL_OUT_W-1:0];
      rsp.is_empty     = (count_ff == '0);
      rsp.is_full      = (count_ff >= CNT_W'(MAX_VERTICES));
   end

   // Vertex count tracks the valid bits
   a_count_matches : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(slot_used_ff))
      else $error("vertex count differs from used slots");

   // A key is only ever written into a free slot
   a_key_to_free : assert property (@(posedge clock) disable iff (reset)
      key_we |-> !slot_used_ff[key_waddr])
      else $error("key write into a used slot");

   // Edge writes need both ends found, apart from the row/column wipe
   a_edge_ends : assert property (@(posedge clock) disable iff (reset)
      edge_we |-> (state_ff == ST_CLEAR) || (a_hit_ff && b_hit_ff))
      else $error("edge write without both vertices");

   // An accepted request starts a key scan
   a_accept_scans : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SEARCH) && (cnt_ff == '0))
      else $error("request accepted without starting a scan");

endmodule

`default_nettype wire
